/* design/tzh_pkg.sv */
`default_nettype none

package tzh_pkg;

    // Field widths
    localparam int TEMP_WIDTH = 13;
    localparam int CFG_WIDTH  = 12;
    localparam int ZONE_W     = 3;
    localparam int NUM_ZONES  = 5;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int CMP_W      = (TEMP_WIDTH > CFG_WIDTH) ? TEMP_WIDTH : CFG_WIDTH;

    typedef logic signed [TEMP_WIDTH-1:0] t_temp;
    typedef logic signed [CFG_WIDTH-1:0]  t_bound;
    typedef logic signed [CMP_W-1:0]      t_cmp;
    typedef logic [ZONE_W-1:0]            t_zone;
    typedef logic [REG_IDX_W-1:0]         t_reg_idx;

    // Zone codes
    localparam t_zone ZONE_COLD    = 3'd0;
    localparam t_zone ZONE_COOL    = 3'd1;
    localparam t_zone ZONE_NORMAL  = 3'd2;
    localparam t_zone ZONE_WARM    = 3'd3;
    localparam t_zone ZONE_HOT     = 3'd4;
    localparam t_zone ZONE_UNKNOWN = 3'd5;

    // Register indexes
    localparam t_reg_idx REG_ZONE1_LOW  = 3'd0;
    localparam t_reg_idx REG_ZONE2_LOW  = 3'd1;
    localparam t_reg_idx REG_ZONE3_LOW  = 3'd2;
    localparam t_reg_idx REG_ZONE4_LOW  = 3'd3;
    localparam t_reg_idx REG_ZONE0_HIGH = 3'd4;
    localparam t_reg_idx REG_ZONE1_HIGH = 3'd5;
    localparam t_reg_idx REG_ZONE2_HIGH = 3'd6;
    localparam t_reg_idx REG_ZONE3_HIGH = 3'd7;

    // Fixed outer bounds of the cold and hot zones
    localparam t_bound BOUND_MIN = -12'sd2000;
    localparam t_bound BOUND_MAX = 12'sd2000;

    // Register reset values
    localparam t_bound ZONE1_LOW_RST  = -12'sd80;
    localparam t_bound ZONE2_LOW_RST  = 12'sd20;
    localparam t_bound ZONE3_LOW_RST  = 12'sd400;
    localparam t_bound ZONE4_LOW_RST  = 12'sd550;
    localparam t_bound ZONE0_HIGH_RST = -12'sd50;
    localparam t_bound ZONE1_HIGH_RST = 12'sd50;
    localparam t_bound ZONE2_HIGH_RST = 12'sd430;
    localparam t_bound ZONE3_HIGH_RST = 12'sd580;

    typedef struct packed {
        t_bound zone1_low;
        t_bound zone2_low;
        t_bound zone3_low;
        t_bound zone4_low;
        t_bound zone0_high;
        t_bound zone1_high;
        t_bound zone2_high;
        t_bound zone3_high;
    } t_bounds;

    typedef struct packed {
        logic  found;
        t_zone zone;
    } t_search;

    function automatic t_cmp ext_bound(input t_bound b);
        return t_cmp'(b);
    endfunction

    function automatic t_cmp ext_temp(input t_temp t);
        return t_cmp'(t);
    endfunction

endpackage

`default_nettype wire

/* design/tzh_cfg_regs.sv */
`default_nettype none

module tzh_cfg_regs (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire tzh_pkg::t_reg_idx i_cfg_index,
    input  wire tzh_pkg::t_bound   i_cfg_data,
    output tzh_pkg::t_bounds       o_bounds
);

    tzh_pkg::t_bounds r_bounds;
    tzh_pkg::t_bounds n_bounds;

    always_comb begin
        n_bounds = r_bounds;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                tzh_pkg::REG_ZONE1_LOW:  n_bounds.zone1_low  = i_cfg_data;
                tzh_pkg::REG_ZONE2_LOW:  n_bounds.zone2_low  = i_cfg_data;
                tzh_pkg::REG_ZONE3_LOW:  n_bounds.zone3_low  = i_cfg_data;
                tzh_pkg::REG_ZONE4_LOW:  n_bounds.zone4_low  = i_cfg_data;
                tzh_pkg::REG_ZONE0_HIGH: n_bounds.zone0_high = i_cfg_data;
                tzh_pkg::REG_ZONE1_HIGH: n_bounds.zone1_high = i_cfg_data;
                tzh_pkg::REG_ZONE2_HIGH: n_bounds.zone2_high = i_cfg_data;
                tzh_pkg::REG_ZONE3_HIGH: n_bounds.zone3_high = i_cfg_data;
                default:                 n_bounds = r_bounds;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds.zone1_low  <= tzh_pkg::ZONE1_LOW_RST;
            r_bounds.zone2_low  <= tzh_pkg::ZONE2_LOW_RST;
            r_bounds.zone3_low  <= tzh_pkg::ZONE3_LOW_RST;
            r_bounds.zone4_low  <= tzh_pkg::ZONE4_LOW_RST;
            r_bounds.zone0_high <= tzh_pkg::ZONE0_HIGH_RST;
            r_bounds.zone1_high <= tzh_pkg::ZONE1_HIGH_RST;
            r_bounds.zone2_high <= tzh_pkg::ZONE2_HIGH_RST;
            r_bounds.zone3_high <= tzh_pkg::ZONE3_HIGH_RST;
        end else begin
            r_bounds <= n_bounds;
        end
    end

    assign o_bounds = r_bounds;

endmodule

`default_nettype wire

/* design/tzh_zone_search.sv */
`default_nettype none

module tzh_zone_search (
    input  wire tzh_pkg::t_temp   i_temp,
    input  wire tzh_pkg::t_zone   i_zone,
    input  wire tzh_pkg::t_bounds i_bounds,
    output tzh_pkg::t_search      o_result
);

    tzh_pkg::t_cmp                  t;
    tzh_pkg::t_cmp                  lo [tzh_pkg::NUM_ZONES];
    tzh_pkg::t_cmp                  hi [tzh_pkg::NUM_ZONES];
    tzh_pkg::t_cmp                  en [tzh_pkg::NUM_ZONES];
    logic [tzh_pkg::NUM_ZONES-1:0]  in_zone;
    logic [tzh_pkg::NUM_ZONES-1:0]  above_entry;
    logic [tzh_pkg::NUM_ZONES-1:0]  below_low;
    logic [tzh_pkg::NUM_ZONES-1:0]  at_high;
    logic                           known;
    logic                           go_down;
    logic                           go_up;

    assign t = tzh_pkg::ext_temp(i_temp);

    assign lo[0] = tzh_pkg::ext_bound(tzh_pkg::BOUND_MIN);
    assign lo[1] = tzh_pkg::ext_bound(i_bounds.zone1_low);
    assign lo[2] = tzh_pkg::ext_bound(i_bounds.zone2_low);
    assign lo[3] = tzh_pkg::ext_bound(i_bounds.zone3_low);
    assign lo[4] = tzh_pkg::ext_bound(i_bounds.zone4_low);

    assign hi[0] = tzh_pkg::ext_bound(i_bounds.zone0_high);
    assign hi[1] = tzh_pkg::ext_bound(i_bounds.zone1_high);
    assign hi[2] = tzh_pkg::ext_bound(i_bounds.zone2_high);
    assign hi[3] = tzh_pkg::ext_bound(i_bounds.zone3_high);
    assign hi[4] = tzh_pkg::ext_bound(tzh_pkg::BOUND_MAX);

    // Entry thresholds out of the unknown zone
    assign en[0] = tzh_pkg::ext_bound(tzh_pkg::BOUND_MIN);
    assign en[1] = tzh_pkg::ext_bound(i_bounds.zone1_low);
    assign en[2] = tzh_pkg::ext_bound(i_bounds.zone2_low);
    assign en[3] = tzh_pkg::ext_bound(i_bounds.zone2_high);
    assign en[4] = tzh_pkg::ext_bound(i_bounds.zone3_high);

    always_comb begin
        for (int z = 0; z < tzh_pkg::NUM_ZONES; z++) begin
            below_low[z]   = t < lo[z];
            at_high[z]     = t >= hi[z];
            in_zone[z]     = !below_low[z] && !at_high[z];
            above_entry[z] = t > en[z];
        end
    end

    // Pick the bounds of the held zone
    always_comb begin
        known   = 1'b0;
        go_down = 1'b0;
        go_up   = 1'b0;
        for (int z = 0; z < tzh_pkg::NUM_ZONES; z++) begin
            if (i_zone == tzh_pkg::t_zone'(z)) begin
                known   = 1'b1;
                go_down = below_low[z];
                go_up   = !below_low[z] && at_high[z];
            end
        end
    end

    // Later hits overwrite earlier ones, so scan order sets the priority
    always_comb begin
        o_result.found = 1'b0;
        o_result.zone  = i_zone;
        if (!known) begin
            for (int z = 0; z < tzh_pkg::NUM_ZONES; z++) begin
                if (above_entry[z]) begin
                    o_result.found = 1'b1;
                    o_result.zone  = tzh_pkg::t_zone'(z);
                end
            end
        end else if (go_down) begin
            for (int z = 0; z < tzh_pkg::NUM_ZONES; z++) begin
                if (tzh_pkg::t_zone'(z) < i_zone && in_zone[z]) begin
                    o_result.found = 1'b1;
                    o_result.zone  = tzh_pkg::t_zone'(z);
                end
            end
        end else if (go_up) begin
            for (int z = tzh_pkg::NUM_ZONES - 1; z >= 0; z--) begin
                if (tzh_pkg::t_zone'(z) > i_zone && in_zone[z]) begin
                    o_result.found = 1'b1;
                    o_result.zone  = tzh_pkg::t_zone'(z);
                end
            end
        end
    end

endmodule

`default_nettype wire

/* design/battery_temp_zone_hysteresis.sv */
`default_nettype none

// Channel   Direction  Handshake                   Word
// input     in         i_in_valid / o_in_stall     i_temperature
// output    out        o_out_valid / i_out_stall   o_zone, o_changed, o_previous_zone
// config    in         i_cfg_we (no handshake)     i_cfg_index, i_cfg_data
//
// One word per cycle sustained while the output does not stall; a word passes the input
// register, then the result register, with the zone search between them.
// Synchronous active-low reset: zone returns to unknown, bounds to their defaults.
// A stalled result holds in the result register while the input register still
// takes one more word; the input stalls only when both registers are full.
module battery_temp_zone_hysteresis (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire tzh_pkg::t_temp    i_temperature,

    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output tzh_pkg::t_zone         o_zone,
    output logic                   o_changed,
    output tzh_pkg::t_zone         o_previous_zone,

    input  wire logic              i_cfg_we,
    input  wire tzh_pkg::t_reg_idx i_cfg_index,
    input  wire tzh_pkg::t_bound   i_cfg_data
);

    tzh_pkg::t_bounds bounds;
    tzh_pkg::t_search search;

    // Input register
    logic             r_in_valid;
    tzh_pkg::t_temp   r_temp;

    // Held zone
    tzh_pkg::t_zone   r_zone;

    // Result register
    logic             r_out_valid;
    tzh_pkg::t_zone   r_out_zone;
    logic             r_out_changed;
    tzh_pkg::t_zone   r_out_prev;

    logic             advance;
    logic             in_take;
    tzh_pkg::t_zone   n_zone;

    tzh_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_bounds    (bounds)
    );

    tzh_zone_search u_search (
        .i_temp   (r_temp),
        .i_zone   (r_zone),
        .i_bounds (bounds),
        .o_result (search)
    );

    // Move the sample into the result register when that register is free or drains
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign n_zone     = search.found ? search.zone : r_zone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_zone      <= tzh_pkg::ZONE_UNKNOWN;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_zone      <= n_zone;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_temp <= i_temperature;
        end
        if (advance) begin
            r_out_zone    <= n_zone;
            r_out_changed <= search.found;
            r_out_prev    <= r_zone;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_zone          = r_out_zone;
    assign o_changed       = r_out_changed;
    assign o_previous_zone = r_out_prev;

    // A reported change always moves to a different zone
    a_change_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_changed |-> o_zone != o_previous_zone)
        else $error("changed flag set but zone did not move");

    // Without a change the zone is kept
    a_hold_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_changed |-> o_zone == o_previous_zone)
        else $error("zone moved without changed flag");

    // The held zone always matches the last delivered word
    a_state_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_zone == r_out_zone)
        else $error("held zone differs from last result");

    // Upstream stalls only when both registers are full and downstream stalls
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

/* tb/tb_battery_temp_zone_hysteresis.sv */
`timescale 1ns / 1ps

module tb_battery_temp_zone_hysteresis;

    // One result word: zone after the sample, change flag, zone before it
    typedef struct packed {
        tzh_pkg::t_zone zone;
        logic           changed;
        tzh_pkg::t_zone prev;
    } t_zone_word;

    // One row of the directed table; rows with has_want carry a hand-typed result
    typedef struct packed {
        tzh_pkg::t_temp temp;
        logic           has_want;
        t_zone_word     want;
    } t_dir_row;

    localparam int ITEMS_PER_PHASE = 175;
    localparam int NUM_PHASES      = 8;
    localparam int QUIET_LIMIT     = 2000;   // cycles with no word moving on either side
    localparam int MAX_SHOWN       = 40;     // mismatch lines printed before going quiet
    localparam t_zone_word NO_WANT = '0;

    // Register order from the coldest bound to the hottest in a well-formed setup
    localparam tzh_pkg::t_reg_idx ORDERED_IDX [tzh_pkg::NUM_REGS] = '{
        tzh_pkg::REG_ZONE1_LOW, tzh_pkg::REG_ZONE0_HIGH,
        tzh_pkg::REG_ZONE2_LOW, tzh_pkg::REG_ZONE1_HIGH,
        tzh_pkg::REG_ZONE3_LOW, tzh_pkg::REG_ZONE2_HIGH,
        tzh_pkg::REG_ZONE4_LOW, tzh_pkg::REG_ZONE3_HIGH
    };

    // Directed walk under the reset bounds. Hand-typed rows: samples that leave the
    // unknown zone untouched, the first entry, and extremes where no zone is found.
    localparam int DIR_ROWS = 22;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{tzh_pkg::t_temp'(-4096), 1'b1,
          '{tzh_pkg::ZONE_UNKNOWN, 1'b0, tzh_pkg::ZONE_UNKNOWN}},
        '{tzh_pkg::t_temp'(-2000), 1'b1,
          '{tzh_pkg::ZONE_UNKNOWN, 1'b0, tzh_pkg::ZONE_UNKNOWN}},
        '{tzh_pkg::t_temp'(580),   1'b1,
          '{tzh_pkg::ZONE_WARM,    1'b1, tzh_pkg::ZONE_UNKNOWN}},
        '{tzh_pkg::t_temp'(579),   1'b0, NO_WANT},
        '{tzh_pkg::t_temp'(580),   1'b0, NO_WANT},
        '{tzh_pkg::t_temp'(4095),  1'b1,
          '{tzh_pkg::ZONE_HOT,     1'b0, tzh_pkg::ZONE_HOT}},
        '{tzh_pkg::t_temp'(1999),  1'b0, NO_WANT},
        '{tzh_pkg::t_temp'(549),   1'b0, NO_WANT},
        '{tzh_pkg::t_temp'(399),   1'b0, NO_WANT},
        '{tzh_pkg::t_temp'(19),    1'b0, NO_WANT},
        '{tzh_pkg::t_temp'(49),    1'b0, NO_WANT},
        '{tzh_pkg::t_temp'(50),    1'b0, NO_WANT},
        '{tzh_pkg::t_temp'(-4096), 1'b1,
          '{tzh_pkg::ZONE_NORMAL,  1'b0, tzh_pkg::ZONE_NORMAL}},
        '{tzh_pkg::t_temp'(-2000), 1'b0, NO_WANT},
        '{tzh_pkg::t_temp'(-51),   1'b0, NO_WANT},
        '{tzh_pkg::t_temp'(-50),   1'b0, NO_WANT},
        '{tzh_pkg::t_temp'(-81),   1'b0, NO_WANT},
        '{tzh_pkg::t_temp'(2000),  1'b0, NO_WANT},
        '{tzh_pkg::t_temp'(1234),  1'b0, NO_WANT},
        '{tzh_pkg::t_temp'(-1),    1'b0, NO_WANT},
        '{tzh_pkg::t_temp'(0),     1'b0, NO_WANT},
        '{tzh_pkg::t_temp'(-2048), 1'b0, NO_WANT}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    tzh_pkg::t_temp    i_temperature = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    tzh_pkg::t_zone    o_zone;
    logic              o_changed;
    tzh_pkg::t_zone    o_previous_zone;
    logic              i_cfg_we = 1'b0;
    tzh_pkg::t_reg_idx i_cfg_index = tzh_pkg::REG_ZONE1_LOW;
    tzh_pkg::t_bound   i_cfg_data = '0;

    // Shadow of the block: bounds as last written and the held zone
    tzh_pkg::t_bound bound_reg [tzh_pkg::NUM_REGS];
    tzh_pkg::t_zone  held_zone = tzh_pkg::ZONE_UNKNOWN;
    t_zone_word      pending_zones [$];

    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int zone_changes = 0;
    int burst_left = 0;
    int stall_tick = 0;
    int quiet_cycles = 0;

    battery_temp_zone_hysteresis u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_temperature   (i_temperature),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_zone          (o_zone),
        .o_changed       (o_changed),
        .o_previous_zone (o_previous_zone),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- zone predictor

    function automatic int zone_floor(tzh_pkg::t_zone z);
        case (z)
            tzh_pkg::ZONE_COOL:   return int'(bound_reg[tzh_pkg::REG_ZONE1_LOW]);
            tzh_pkg::ZONE_NORMAL: return int'(bound_reg[tzh_pkg::REG_ZONE2_LOW]);
            tzh_pkg::ZONE_WARM:   return int'(bound_reg[tzh_pkg::REG_ZONE3_LOW]);
            tzh_pkg::ZONE_HOT:    return int'(bound_reg[tzh_pkg::REG_ZONE4_LOW]);
            default:              return int'(tzh_pkg::BOUND_MIN);
        endcase
    endfunction

    // Upper bound is exclusive; the hot zone tops out at the fixed maximum
    function automatic int zone_ceiling(tzh_pkg::t_zone z);
        case (z)
            tzh_pkg::ZONE_COLD:   return int'(bound_reg[tzh_pkg::REG_ZONE0_HIGH]);
            tzh_pkg::ZONE_COOL:   return int'(bound_reg[tzh_pkg::REG_ZONE1_HIGH]);
            tzh_pkg::ZONE_NORMAL: return int'(bound_reg[tzh_pkg::REG_ZONE2_HIGH]);
            tzh_pkg::ZONE_WARM:   return int'(bound_reg[tzh_pkg::REG_ZONE3_HIGH]);
            default:              return int'(tzh_pkg::BOUND_MAX);
        endcase
    endfunction

    // Thresholds used only when leaving the unknown zone
    function automatic int zone_entry(tzh_pkg::t_zone z);
        case (z)
            tzh_pkg::ZONE_COLD:   return int'(tzh_pkg::BOUND_MIN);
            tzh_pkg::ZONE_COOL:   return int'(bound_reg[tzh_pkg::REG_ZONE1_LOW]);
            tzh_pkg::ZONE_NORMAL: return int'(bound_reg[tzh_pkg::REG_ZONE2_LOW]);
            tzh_pkg::ZONE_WARM:   return int'(bound_reg[tzh_pkg::REG_ZONE2_HIGH]);
            default:              return int'(bound_reg[tzh_pkg::REG_ZONE3_HIGH]);
        endcase
    endfunction

    function automatic logic in_zone(tzh_pkg::t_zone z, int s);
        return (s < zone_ceiling(z)) && (s >= zone_floor(z));
    endfunction

    // Advance the held zone by one sample and return the word the block should emit
    function automatic t_zone_word classify_sample(tzh_pkg::t_temp t);
        t_zone_word r;
        int s;
        int cur;
        int hit;
        int z;
        s      = int'(t);
        r.prev = held_zone;
        cur    = (held_zone < tzh_pkg::NUM_ZONES) ? int'(held_zone)
                                                  : int'(tzh_pkg::ZONE_UNKNOWN);
        hit    = -1;
        if (cur == int'(tzh_pkg::ZONE_UNKNOWN)) begin
            // highest zone whose entry threshold the sample strictly exceeds
            for (z = tzh_pkg::NUM_ZONES - 1; z >= 0 && hit < 0; z--)
                if (s > zone_entry(tzh_pkg::t_zone'(z))) hit = z;
        end else if (s < zone_floor(tzh_pkg::t_zone'(cur))) begin
            for (z = cur - 1; z >= 0 && hit < 0; z--)
                if (in_zone(tzh_pkg::t_zone'(z), s)) hit = z;
        end else if (s >= zone_ceiling(tzh_pkg::t_zone'(cur))) begin
            for (z = cur + 1; z < tzh_pkg::NUM_ZONES && hit < 0; z++)
                if (in_zone(tzh_pkg::t_zone'(z), s)) hit = z;
        end
        if (hit >= 0) held_zone = tzh_pkg::t_zone'(hit);
        r.zone    = held_zone;
        r.changed = (hit >= 0);
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    // Mostly land right on a bound (or one or two off), else a plausible sample,
    // and now and then anything the 13-bit field holds.
    function automatic tzh_pkg::t_temp pick_temp();
        int k;
        int j;
        int v;
        k = $urandom_range(0, 9);
        if (k < 6) begin
            j = $urandom_range(0, tzh_pkg::NUM_REGS + 1);
            if (j < tzh_pkg::NUM_REGS)
                v = int'(bound_reg[j]);
            else
                v = (j == tzh_pkg::NUM_REGS) ? int'(tzh_pkg::BOUND_MIN)
                                             : int'(tzh_pkg::BOUND_MAX);
            v = v + int'($urandom_range(0, 4)) - 2;
        end else if (k < 9) begin
            v = int'($urandom_range(0, 4200)) - 2100;
        end else begin
            v = int'($urandom_range(0, 8191)) - 4096;
        end
        return tzh_pkg::t_temp'(v);
    endfunction

    // Send one sample word; called and returns at a falling edge. The sender runs
    // in bursts: when a burst is used up, drop valid for a random gap first.
    task automatic send_temp(tzh_pkg::t_temp t, logic has_want, t_zone_word want);
        t_zone_word guess;
        if (burst_left == 0) begin
            i_in_valid = 1'b0;
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        i_in_valid    = 1'b1;
        i_temperature = t;
        // hold the word until the block takes it
        do @(posedge i_clk); while (o_in_stall);
        guess = classify_sample(t);
        pending_zones.push_back(has_want ? want : guess);
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // Stop sending and hold off until every result is back
    task automatic wait_drained();
        i_in_valid = 1'b0;
        burst_left = 0;
        while (pending_zones.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_bound(tzh_pkg::t_reg_idx idx, tzh_pkg::t_bound val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        bound_reg[idx] = val;
        @(negedge i_clk);
    endtask

    // Load a fresh set of bounds for the given phase; the block is idle by now
    task automatic load_bounds(int ph);
        tzh_pkg::t_bound vals [tzh_pkg::NUM_REGS];
        int v;
        int k;
        for (k = 0; k < tzh_pkg::NUM_REGS; k++) vals[k] = bound_reg[k];
        case (ph)
            1: for (k = 0; k < tzh_pkg::NUM_REGS; k++) vals[k] = tzh_pkg::t_bound'(-1999);
            2: for (k = 0; k < tzh_pkg::NUM_REGS; k++) vals[k] = tzh_pkg::t_bound'(1999);
            3, 5: begin
                // well-formed overlapping zones, random spacing
                v = -1999 + int'($urandom_range(0, 300));
                for (k = 0; k < tzh_pkg::NUM_REGS; k++) begin
                    vals[ORDERED_IDX[k]] = tzh_pkg::t_bound'(v);
                    v = v + int'($urandom_range(1, 450));
                end
            end
            4: for (k = 0; k < tzh_pkg::NUM_REGS; k++)
                vals[k] = tzh_pkg::t_bound'(int'($urandom_range(0, 3998)) - 1999);
            6: for (k = 0; k < tzh_pkg::NUM_REGS; k++)
                case ($urandom_range(0, 2))
                    0:       vals[k] = tzh_pkg::t_bound'(-1999);
                    1:       vals[k] = tzh_pkg::t_bound'(1999);
                    default: vals[k] = tzh_pkg::t_bound'(int'($urandom_range(0, 3998)) - 1999);
                endcase
            default: begin
                vals[tzh_pkg::REG_ZONE1_LOW]  = tzh_pkg::ZONE1_LOW_RST;
                vals[tzh_pkg::REG_ZONE2_LOW]  = tzh_pkg::ZONE2_LOW_RST;
                vals[tzh_pkg::REG_ZONE3_LOW]  = tzh_pkg::ZONE3_LOW_RST;
                vals[tzh_pkg::REG_ZONE4_LOW]  = tzh_pkg::ZONE4_LOW_RST;
                vals[tzh_pkg::REG_ZONE0_HIGH] = tzh_pkg::ZONE0_HIGH_RST;
                vals[tzh_pkg::REG_ZONE1_HIGH] = tzh_pkg::ZONE1_HIGH_RST;
                vals[tzh_pkg::REG_ZONE2_HIGH] = tzh_pkg::ZONE2_HIGH_RST;
                vals[tzh_pkg::REG_ZONE3_HIGH] = tzh_pkg::ZONE3_HIGH_RST;
            end
        endcase
        for (k = 0; k < tzh_pkg::NUM_REGS; k++)
            write_bound(tzh_pkg::t_reg_idx'(k), vals[k]);
        i_cfg_we = 1'b0;
    endtask

    // ---------------------------------------------------------------- receiver

    // Stall on a pattern that steps through its modes in turn: open windows, sparse and
    // dense random stalls, regular beats, and long runs of stall.
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1;
        case ((stall_tick >> 6) % 8)
            0, 1:    i_out_stall <= 1'b0;
            2:       i_out_stall <= ($urandom_range(0, 3) == 0);
            3:       i_out_stall <= ($urandom_range(0, 3) != 0);
            4:       i_out_stall <= stall_tick[2];
            5:       i_out_stall <= (stall_tick[1:0] == 2'b00);
            6:       i_out_stall <= ($urandom_range(0, 1) == 1);
            default: i_out_stall <= (stall_tick[5:4] == 2'b11);
        endcase
    end

    // ---------------------------------------------------------------- result check

    always @(posedge i_clk) begin
        t_zone_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_zones.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: result word with nothing expected: %s %0d %0d %0d",
                             $time, "zone/changed/prev", o_zone, o_changed,
                             o_previous_zone);
            end else begin
                want = pending_zones.pop_front();
                if (o_changed) zone_changes++;
                if (o_zone !== want.zone) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: zone expected %0d got %0d", $time, want.zone, o_zone);
                end
                if (o_changed !== want.changed) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: changed expected %0d got %0d",
                                 $time, want.changed, o_changed);
                end
                if (o_previous_zone !== want.prev) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: previous_zone expected %0d got %0d",
                                 $time, want.prev, o_previous_zone);
                end
            end
        end
    end

    // Watchdog: give up when no word moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("battery_temp_zone_hysteresis regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        int r;
        int ph;
        int n;
        bound_reg[tzh_pkg::REG_ZONE1_LOW]  = tzh_pkg::ZONE1_LOW_RST;
        bound_reg[tzh_pkg::REG_ZONE2_LOW]  = tzh_pkg::ZONE2_LOW_RST;
        bound_reg[tzh_pkg::REG_ZONE3_LOW]  = tzh_pkg::ZONE3_LOW_RST;
        bound_reg[tzh_pkg::REG_ZONE4_LOW]  = tzh_pkg::ZONE4_LOW_RST;
        bound_reg[tzh_pkg::REG_ZONE0_HIGH] = tzh_pkg::ZONE0_HIGH_RST;
        bound_reg[tzh_pkg::REG_ZONE1_HIGH] = tzh_pkg::ZONE1_HIGH_RST;
        bound_reg[tzh_pkg::REG_ZONE2_HIGH] = tzh_pkg::ZONE2_HIGH_RST;
        bound_reg[tzh_pkg::REG_ZONE3_HIGH] = tzh_pkg::ZONE3_HIGH_RST;

        // hold reset, then release it on a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed walk under the reset bounds
        for (r = 0; r < DIR_ROWS; r++)
            send_temp(DIR_TAB[r].temp, DIR_TAB[r].has_want, DIR_TAB[r].want);

        // random phases; each new bound set goes in only once the block has drained
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                load_bounds(ph);
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_temp(pick_temp(), 1'b0, NO_WANT);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (pending_zones.size() != 0) begin
            mismatches++;
            $display("%0t: %0d result words never arrived", $time, pending_zones.size());
        end

        $display("Sent %0d temperature samples over %0d bound settings; checked %0d results,",
                 items_sent, NUM_PHASES, results_seen);
        $display("%0d of them zone changes, with bursty input and patterned output stalls.",
                 zone_changes);
        if (mismatches == 0)
            $display("battery_temp_zone_hysteresis regression: pass");
        else
            $display("battery_temp_zone_hysteresis regression: fail");
        $finish;
    end

endmodule
